// ----- rtl/generation_validated_edge_table_defines.svh -----
// assertion helpers used by the rtl
`ifndef GENERATION_VALIDATED_EDGE_TABLE_DEFINES_SVH
`define GENERATION_VALIDATED_EDGE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GVET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GVET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gvet_pkg.sv -----
package gvet_pkg;

  localparam int TABLE_BITS  = 12;
  localparam int PROBE_LIMIT = 8;

  // one bank per probe position, so a whole probe window is read in a single access
  localparam int BANK_BITS = ($clog2(PROBE_LIMIT) < 1) ? 1 : $clog2(PROBE_LIMIT);
  localparam int NUM_BANKS = 1 << BANK_BITS;
  localparam int ROW_BITS  = TABLE_BITS - BANK_BITS;
  localparam int ROW_W     = (ROW_BITS > 0) ? ROW_BITS : 1;
  localparam int ROWS      = 1 << ROW_BITS;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam int          HASH_SHIFT = 3;

  localparam logic KIND_CHECK    = 1'b0;
  localparam logic KIND_ROLLBACK = 1'b1;

  typedef struct packed {
    logic [63:0] slot;
    logic [63:0] child;
    logic [63:0] generation;
    logic [31:0] epoch;
  } gvet_entry_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] slot_address;
    logic [63:0] child_pointer;
    logic [63:0] child_generation;
    logic        child_readable;
  } gvet_item_t;

  typedef struct packed {
    logic                 hit;
    logic [BANK_BITS-1:0] bank;
    logic                 recycled;
  } gvet_probe_res_t;

endpackage

// ----- rtl/gvet_if.sv -----
interface gvet_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] slot_address;
  logic [63:0] child_pointer;
  logic [63:0] child_generation;
  logic        child_readable;

  modport source (
    output valid, kind, slot_address, child_pointer, child_generation, child_readable,
    input  ready
  );
  modport sink (
    input  valid, kind, slot_address, child_pointer, child_generation, child_readable,
    output ready
  );
endinterface

interface gvet_out_if;
  logic valid;
  logic ready;
  logic recycled;

  modport source (output valid, recycled, input ready);
  modport sink (input valid, recycled, output ready);
endinterface

// ----- rtl/gvet_ram.sv -----
module gvet_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gvet_probe.sv -----
module gvet_probe import gvet_pkg::*; (
  input  gvet_entry_t [NUM_BANKS-1:0] rd_data,
  input  logic [63:0]                 slot,
  input  logic [63:0]                 child,
  input  logic [63:0]                 generation,
  input  logic [31:0]                 epoch,
  input  logic [BANK_BITS-1:0]        base_bank,
  output gvet_probe_res_t             res
);

  logic [NUM_BANKS-1:0] match;
  logic [NUM_BANKS-1:0] claim;
  logic [NUM_BANKS-1:0] rec;

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      match[b] = rd_data[b].slot == slot;
      claim[b] = (rd_data[b].slot == 64'd0) || (rd_data[b].epoch != epoch);
      rec[b]   = match[b] && (rd_data[b].epoch == epoch) &&
                 (rd_data[b].child == child) && (rd_data[b].generation != generation);
    end
  end

  // walk the window in probe order, first slot match or claimable entry wins
  always_comb begin
    logic [BANK_BITS-1:0] b;
    res = '0;
    for (int i = 0; i < PROBE_LIMIT; i++) begin
      b = BANK_BITS'(base_bank + BANK_BITS'(i));
      if (!res.hit && (match[b] || claim[b])) begin
        res.hit      = 1'b1;
        res.bank     = b;
        res.recycled = rec[b];
      end
    end
  end

endmodule

// ----- rtl/generation_validated_edge_table.sv -----
// channel  dir  transaction
// in_chan  in   kind, slot_address, child_pointer, child_generation, child_readable
// out_chan out  recycled, one per input transaction, in order
//
// an item passes a bank read of the probe window, then compare and write-back,
// with the next item accepted in the write-back cycle
// the read step comes from the registered read port of the entry banks
// after reset a clearing pass zeroes one row of all banks per cycle, over all 512 rows
// (2^(TABLE_BITS-BANK_BITS)), during which no input is accepted
// a stalled result holds the block in write-back until out_chan takes it
`include "generation_validated_edge_table_defines.svh"

module generation_validated_edge_table import gvet_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  gvet_in_if.sink   in_chan,
  gvet_out_if.source out_chan
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  gvet_item_t            item_r;
  logic [TABLE_BITS-1:0] base_r;
  logic [31:0]           epoch_r;
  logic                  out_valid_r;
  logic                  out_recycled_r;
  logic [ROW_W-1:0]      clr_row_r;

  logic [BANK_BITS-1:0]        base_bank;
  logic [ROW_W-1:0]            base_row;
  logic [ROW_W-1:0]            base_row_inc;
  logic [ROW_W-1:0]            probe_row [NUM_BANKS];
  logic [NUM_BANKS-1:0]        bank_we;
  logic [ROW_W-1:0]            bank_waddr [NUM_BANKS];
  gvet_entry_t                 bank_wdata;
  gvet_entry_t [NUM_BANKS-1:0] rd_data;
  gvet_entry_t                 new_entry;
  gvet_probe_res_t             pres;
  logic                        out_free;
  logic                        eval_done;
  logic                        in_ready;
  logic                        accept;
  logic                        do_check;
  logic                        wr_en;
  logic [TABLE_BITS-1:0]       hash;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign eval_done = (state_r == ST_EVAL) && out_free;
  assign in_ready  = (state_r == ST_IDLE) || eval_done;
  assign accept    = in_chan.valid && in_ready;
  assign do_check  = (item_r.kind == KIND_CHECK) && item_r.child_readable;
  assign wr_en     = eval_done && do_check && pres.hit;

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.recycled = out_recycled_r;

  // low bits of the product only need low bits of the operands
  assign hash = TABLE_BITS'(in_chan.slot_address[HASH_SHIFT +: TABLE_BITS] *
                            HASH_MULT[TABLE_BITS-1:0]);

  assign base_bank    = base_r[BANK_BITS-1:0];
  assign base_row     = ROW_W'(base_r >> BANK_BITS);
  assign base_row_inc = (ROW_BITS == 0) ? '0 : ROW_W'(base_row + 1'b1);

  // banks below the base bank hold the wrapped part of the window, one row up
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      probe_row[b] = (BANK_BITS'(b) >= base_bank) ? base_row : base_row_inc;
    end
  end

  assign new_entry.slot       = item_r.slot_address;
  assign new_entry.child      = item_r.child_pointer;
  assign new_entry.generation = item_r.child_generation;
  assign new_entry.epoch      = epoch_r;

  assign bank_wdata = (state_r == ST_CLEAR) ? '0 : new_entry;

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_we[b]    = (state_r == ST_CLEAR) || (wr_en && (pres.bank == BANK_BITS'(b)));
      bank_waddr[b] = (state_r == ST_CLEAR) ? clr_row_r : probe_row[b];
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    gvet_ram #(
      .WIDTH  ($bits(gvet_entry_t)),
      .ADDR_W (ROW_W)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata),
      .re    (state_r == ST_READ),
      .raddr (probe_row[g]),
      .rdata (rd_data[g])
    );
  end

  gvet_probe u_probe (
    .rd_data    (rd_data),
    .slot       (item_r.slot_address),
    .child      (item_r.child_pointer),
    .generation (item_r.child_generation),
    .epoch      (epoch_r),
    .base_bank  (base_bank),
    .res        (pres)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_row_r == ROW_W'(ROWS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) state_nxt = accept ? ST_READ : ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      epoch_r     <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_row_r <= ROW_W'(clr_row_r + 1'b1);
      end
      if (eval_done) begin
        out_valid_r <= 1'b1;
        if (item_r.kind == KIND_ROLLBACK) begin
          epoch_r <= epoch_r + 32'd1;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind             <= in_chan.kind;
      item_r.slot_address     <= in_chan.slot_address;
      item_r.child_pointer    <= in_chan.child_pointer;
      item_r.child_generation <= in_chan.child_generation;
      item_r.child_readable   <= in_chan.child_readable;
      base_r                  <= hash;
    end
    if (eval_done) begin
      out_recycled_r <= do_check && pres.hit && pres.recycled;
    end
  end

  `GVET_ASSERT_NEXT(a_accept_reads, accept, state_r == ST_READ, "accept did not start a read")
  `GVET_ASSERT_NEXT(a_stall_holds, (state_r == ST_EVAL) && !out_free, (state_r == ST_EVAL) && out_valid_r, "stalled result lost")
  `GVET_ASSERT_NOW(a_one_write, state_r != ST_CLEAR, $onehot0(bank_we), "more than one bank written")
  `GVET_ASSERT_NEXT(a_epoch_rollback, !(eval_done && (item_r.kind == KIND_ROLLBACK)), $stable(epoch_r), "epoch moved without rollback")

endmodule
